>>> src/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int SLOT_WORDS  = 32;
  localparam int WORD_BITS   = 32;
  localparam int TOTAL_SLOTS = SLOT_WORDS * WORD_BITS;

  localparam int WORD_AW = $clog2(SLOT_WORDS);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int LIM_W   = 11;   // active_bits register width
  localparam int IDX_W   = 10;   // slot_index / bit_index width

  localparam logic [LIM_W-1:0] ACTIVE_RESET = LIM_W'(1024);
  localparam logic [LIM_W-1:0] LIMIT_MAX    = LIM_W'(TOTAL_SLOTS);

  typedef enum logic [1:0] {
    REQ_PEEK  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_RANGE       = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } ram_req_t;

endpackage

>>> src/bsa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bsa_bitmap_ram
// Usage bitmap storage: one write and one registered read port. A word
// never written since reset reads as all free.
// ----------------------------------------------------------------------------
module bsa_bitmap_ram
  import bsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ram_req_t             req,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [SLOT_WORDS];
  logic [SLOT_WORDS-1:0] written;
  logic [WORD_BITS-1:0] rd_word;
  logic                 rd_written;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word    <= mem[req.rd_addr];
      rd_written <= written[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.wr_en) begin
      written[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_written ? rd_word : '0;

endmodule

>>> src/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: scans the bitmap one word per cycle, does the
// read-modify-write, and holds the result word for the output side.
// ----------------------------------------------------------------------------
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [LIM_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_t                 in_req,
  input  logic [IDX_W-1:0]     in_idx,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_slot,
  output logic                 out_used,
  output status_t              out_status,
  output ram_req_t             ram_req,
  input  logic [WORD_BITS-1:0] ram_rd_data
);

  state_t               state, state_next;
  logic [LIM_W-1:0]     active_bits;
  req_t                 req;
  logic [IDX_W-1:0]     idx;
  logic [WORD_AW-1:0]   word_ptr, word_ptr_next;
  logic [IDX_W-1:0]     res_slot, res_slot_next;
  logic                 res_used, res_used_next;
  status_t              res_status, res_status_next;
  logic                 res_we;

  logic [LIM_W-1:0]     limit;
  logic [LIM_W-1:0]     base;
  logic [LIM_W-1:0]     rem;
  logic [LIM_W:0]       base_end;
  logic [WORD_BITS-1:0] word_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic                 found;
  logic [BIT_W-1:0]     found_bit;
  logic                 last_word;
  logic [BIT_W-1:0]     chk_bit;
  logic                 chk_used;
  logic                 accept;
  logic                 out_free;

  assign limit    = (active_bits > LIMIT_MAX) ? LIMIT_MAX : active_bits;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // scan window: bits of the current word that lie below the limit
  assign base      = LIM_W'({word_ptr, {BIT_W{1'b0}}});
  assign rem       = limit - base;
  assign base_end  = {1'b0, base} + (LIM_W+1)'(WORD_BITS);
  assign word_mask = (rem >= LIM_W'(WORD_BITS)) ? '1
                   : ((WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1));
  assign free_bits = ~ram_rd_data & word_mask;
  assign last_word = (word_ptr == WORD_AW'(SLOT_WORDS - 1))
                  || (base_end >= {1'b0, limit});

  always_comb begin
    found     = 1'b0;
    found_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        found     = 1'b1;
        found_bit = BIT_W'(i);
      end
    end
  end

  assign chk_bit  = idx[BIT_W-1:0];
  assign chk_used = ram_rd_data[chk_bit];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_req inside {REQ_PEEK, REQ_ALLOC}) begin
            state_next = (limit == '0) ? S_DONE : S_SCAN;
          end else begin
            state_next = ({1'b0, in_idx} >= limit) ? S_DONE : S_CHECK;
          end
        end
      end
      S_SCAN: begin
        if (found || last_word) begin
          state_next = S_DONE;
        end
      end
      S_CHECK: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready        = 1'b0;
    ram_req         = '0;
    word_ptr_next   = word_ptr;
    res_we          = 1'b0;
    res_slot_next   = '0;
    res_used_next   = 1'b0;
    res_status_next = ST_OK;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_req inside {REQ_PEEK, REQ_ALLOC}) begin
            word_ptr_next = '0;
            if (limit == '0) begin
              res_we          = 1'b1;
              res_status_next = ST_FULL;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = '0;
            end
          end else if ({1'b0, in_idx} >= limit) begin
            res_we          = 1'b1;
            res_slot_next   = in_idx;
            res_status_next = ST_RANGE;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = in_idx[IDX_W-1:BIT_W];
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          res_we        = 1'b1;
          res_slot_next = IDX_W'({word_ptr, found_bit});
          if (req == REQ_ALLOC) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = word_ptr;
            ram_req.wr_data = ram_rd_data | (WORD_BITS'(1) << found_bit);
          end
        end else if (last_word) begin
          res_we          = 1'b1;
          res_status_next = ST_FULL;
        end else begin
          word_ptr_next   = word_ptr + WORD_AW'(1);
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = word_ptr + WORD_AW'(1);
        end
      end
      S_CHECK: begin
        res_we        = 1'b1;
        res_slot_next = idx;
        if (req == REQ_QUERY) begin
          res_used_next = chk_used;
        end else if (!chk_used) begin
          res_status_next = ST_DOUBLE_FREE;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = idx[IDX_W-1:BIT_W];
          ram_req.wr_data = ram_rd_data & ~(WORD_BITS'(1) << chk_bit);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active_bits <= ACTIVE_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        active_bits <= cfg_wdata;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_req;
      idx <= in_idx;
    end
    word_ptr <= word_ptr_next;
    if (res_we) begin
      res_slot   <= res_slot_next;
      res_used   <= res_used_next;
      res_status <= res_status_next;
    end
    if (state == S_DONE && out_free) begin
      out_slot   <= res_slot;
      out_used   <= res_used;
      out_status <= res_status;
    end
  end

  // writes come only from the last step of a request
  a_wr_state: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> (state == S_SCAN || state == S_CHECK))
    else $error("bitmap write outside scan/check");

  // a write ends the request, so it never overlaps a read in flight
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> !ram_req.rd_en)
    else $error("bitmap read and write in the same cycle");

  // after a write the next cycle holds the finished result
  a_wr_done: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |=> (state == S_DONE))
    else $error("bitmap write not followed by result");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word raised without a finished request");

endmodule

>>> src/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Find-first-zero slot allocator over a 1024-slot usage bitmap.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: bit_index
//   m_*      out  m_tvalid/m_tready  m_tuser: status; m_tdata: slot_index, in_use
//   cfg_*    in   cfg_we             cfg_wdata: active_bits
//
// Peek/allocate scan N words from word 0, N = 1..32;
// a zero slot limit skips the scan.
// The scan reads one bitmap word per cycle from the bitmap memory.
// Free/query read and check one word; an out-of-range index skips the read.
// One request is in work at a time; a finished word waits in the output
// register while the next request is accepted.
// Reset marks every word free at once through per-word written flags.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator
  import bsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [10:0]      cfg_wdata,   // active_bits
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,     // [9:0] bit_index
  input  logic [1:0]       s_tuser,     // [1:0] req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,     // [9:0] slot_index, [10] in_use
  output logic [1:0]       m_tuser      // [1:0] status
);

  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] ram_rd_data;
  logic [IDX_W-1:0]     out_slot;
  logic                 out_used;
  status_t              out_status;
  req_t                 in_req;

  assign in_req = req_t'(s_tuser);

  bsa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_req      (in_req),
    .in_idx      (s_tdata[IDX_W-1:0]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_slot    (out_slot),
    .out_used    (out_used),
    .out_status  (out_status),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  bsa_bitmap_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  assign m_tdata = {5'd0, out_used, out_slot};
  assign m_tuser = out_status;

endmodule
